// File: rtl/core/dmxr_pkg.sv
package dmxr_pkg;

    // Field widths
    localparam int SLOT_W  = 10;
    localparam int WIN_W   = SLOT_W + 1;
    localparam int BYTE_W  = 8;
    localparam int CHAN_W  = 3;

    // Special character codes
    localparam logic [BYTE_W-1:0] BREAK_DATA = 8'h00;
    localparam logic [BYTE_W-1:0] SC_DMX     = 8'h00;
    localparam logic [BYTE_W-1:0] SC_RDM     = 8'hCC;

    // Address after reset
    localparam logic [SLOT_W-1:0] ADDR_RESET = 10'd1;

    // Receive phase, encoded as reported on rx_mode
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BREAK = 2'd1,
        PH_DMX   = 2'd2,
        PH_RDM   = 2'd3
    } phase_t;

    // One result word
    typedef struct packed {
        logic              write_valid;
        logic [CHAN_W-1:0] channel_index;
        logic [BYTE_W-1:0] channel_value;
        phase_t            rx_mode;
        logic              frame_end;
    } res_t;

endpackage

// File: rtl/core/dmxr_slot_decode.sv
module dmxr_slot_decode
    import dmxr_pkg::*;
#(
    parameter int FIXTURE_CHANNELS = 7,
    parameter int SLOTS_PER_FRAME  = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              stop_bit,
    input  logic [SLOT_W-1:0] device_address,
    output res_t              res
);

    localparam logic [WIN_W-1:0]  WIN_LEN   = WIN_W'(FIXTURE_CHANNELS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS_PER_FRAME);

    phase_t            phase_reg, phase_next;
    logic              armed_reg, armed_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic              is_break;
    logic [SLOT_W-1:0] slot_inc;
    logic [WIN_W-1:0]  slot_wide;
    logic [WIN_W-1:0]  addr_wide;
    logic              in_window;
    logic [CHAN_W-1:0] offset;

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            armed_reg <= 1'b0;
            slot_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            armed_reg <= armed_next;
            slot_reg  <= slot_next;
        end
    end

    // Slot window compare, done one bit wider than the address
    assign is_break  = (!stop_bit) && (rx_byte == BREAK_DATA);
    assign slot_inc  = slot_reg + SLOT_W'(1);
    assign slot_wide = {1'b0, slot_inc};
    assign addr_wide = {1'b0, device_address};
    assign in_window = (slot_wide >= addr_wide) && (slot_wide < (addr_wide + WIN_LEN));
    // only the low bits of the offset are reported
    assign offset    = slot_inc[CHAN_W-1:0] - device_address[CHAN_W-1:0];

    // Next state and result
    always_comb
    begin
        phase_next = phase_reg;
        armed_next = armed_reg;
        slot_next  = slot_reg;
        res        = '0;

        if (is_break)
        begin
            armed_next = 1'b1;
            phase_next = PH_BREAK;
        end
        else if (armed_reg && stop_bit)
        begin
            case (phase_reg)
                PH_BREAK:
                begin
                    if (rx_byte == SC_DMX)
                    begin
                        phase_next = PH_DMX;
                        slot_next  = '0;
                    end
                    else if (rx_byte == SC_RDM)
                        phase_next = PH_RDM;
                    else
                        phase_next = PH_IDLE;
                end
                PH_DMX:
                begin
                    slot_next = slot_inc;
                    if (in_window)
                    begin
                        res.write_valid   = 1'b1;
                        res.channel_index = offset;
                        res.channel_value = rx_byte;
                    end
                    // last slot closes the frame, window or not
                    if (slot_inc == LAST_SLOT)
                    begin
                        slot_next     = '0;
                        armed_next    = 1'b0;
                        res.frame_end = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        res.rx_mode = phase_next;
    end

endmodule

// File: rtl/core/dmxr_out_stage.sv
module dmxr_out_stage
    import dmxr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t res_in,
    input  logic out_ready,
    output logic can_load,
    output logic out_valid,
    output res_t res_out
);

    logic out_valid_reg, out_valid_next;
    res_t res_reg;

    // Free when empty or when the held word leaves this cycle
    assign can_load       = (!out_valid_reg) || out_ready;
    assign out_valid_next = load || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    assign out_valid = out_valid_reg;
    assign res_out   = res_reg;

endmodule

// File: rtl/core/dmxr_slot_receiver_top.sv
// DMX512 slot receiver. Each input word is one received UART character (data
// byte plus ninth stop bit); each yields exactly one result word giving the
// phase after that byte and, for slots device_address up to
// device_address + FIXTURE_CHANNELS - 1, a channel write. A zero byte with
// stop bit 0 is a break and rearms start-code detection; slot SLOTS_PER_FRAME
// closes the frame. A word is taken every clock cycle while in_ready is high;
// it is held in the input register and decoded into the result register once
// the output stage can load; the result register holds while out_ready is low
// and the input register holds while the result register cannot load.
// device_address resets to 1 and is written through cfg_wr_en/cfg_wr_data
// only while no word is in flight: a rule for the user, unchecked by the block.
module dmx512_slot_receiver
    import dmxr_pkg::*;
#(
    parameter int FIXTURE_CHANNELS = 7,
    parameter int SLOTS_PER_FRAME  = 512
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [SLOT_W-1:0] cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              stop_bit,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              write_valid,
    output logic [CHAN_W-1:0] channel_index,
    output logic [BYTE_W-1:0] channel_value,
    output logic [1:0]        rx_mode,
    output logic              frame_end
);

    logic [SLOT_W-1:0] addr_reg;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              stop_reg;
    logic              can_load;
    logic              advance;
    res_t              res_dec;
    res_t              res_q;

    // Address register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            addr_reg <= ADDR_RESET;
        else if (cfg_wr_en)
            addr_reg <= cfg_wr_data;
    end

    // Input register
    assign advance       = in_valid_reg && can_load;
    assign in_ready      = (!in_valid_reg) || advance;
    assign in_valid_next = (in_valid && in_ready) || (in_valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= rx_byte;
            stop_reg <= stop_bit;
        end
    end

    dmxr_slot_decode #(
        .FIXTURE_CHANNELS (FIXTURE_CHANNELS),
        .SLOTS_PER_FRAME  (SLOTS_PER_FRAME)
    ) u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .rx_byte        (byte_reg),
        .stop_bit       (stop_reg),
        .device_address (addr_reg),
        .res            (res_dec)
    );

    dmxr_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .res_in    (res_dec),
        .out_ready (out_ready),
        .can_load  (can_load),
        .out_valid (out_valid),
        .res_out   (res_q)
    );

    assign write_valid   = res_q.write_valid;
    assign channel_index = res_q.channel_index;
    assign channel_value = res_q.channel_value;
    assign rx_mode       = res_q.rx_mode;
    assign frame_end     = res_q.frame_end;

endmodule
